// ===== src/uadw_pkg.sv =====
// Package of the USB audio descriptor walker: state encoding, record and verdict codes,
// descriptor constants and the command and status bundles between controller and datapath.
// Depends on nothing.
package uadw_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_RATE_RD,
        ST_RATE,
        ST_VERDICT
    } uadw_state_t;

    // Record kinds.
    localparam logic [2:0] KIND_INTERFACE = 3'd0;
    localparam logic [2:0] KIND_VERSION   = 3'd1;
    localparam logic [2:0] KIND_FORMAT    = 3'd2;
    localparam logic [2:0] KIND_RATE      = 3'd3;
    localparam logic [2:0] KIND_ENDPOINT  = 3'd4;
    localparam logic [2:0] KIND_VERDICT   = 3'd5;

    // Verdict codes.
    localparam logic [2:0] VC_NOT_AUDIO     = 3'd0;
    localparam logic [2:0] VC_ASYNC_EXPLICIT = 3'd1;
    localparam logic [2:0] VC_ASYNC_IMPLICIT = 3'd2;
    localparam logic [2:0] VC_ASYNC_NONE    = 3'd3;
    localparam logic [2:0] VC_ADAPTIVE_SYNC = 3'd4;

    // Bit positions in the seen flags.
    localparam int FLAG_AUDIO = 0;
    localparam int FLAG_ASYNC = 1;
    localparam int FLAG_EXPL  = 2;
    localparam int FLAG_IMPL  = 3;

    // Descriptor types and audio class codes.
    localparam logic [7:0] DT_INTERFACE    = 8'h04;
    localparam logic [7:0] DT_CS_INTERFACE = 8'h24;
    localparam logic [7:0] DT_ENDPOINT     = 8'h05;
    localparam logic [7:0] CLASS_AUDIO     = 8'h01;
    localparam logic [7:0] SUBCLASS_CTRL   = 8'h01;
    localparam logic [7:0] SUBCLASS_STREAM = 8'h02;
    localparam logic [7:0] SUBTYPE_HEADER  = 8'h01;
    localparam logic [7:0] SUBTYPE_FORMAT  = 8'h02;
    localparam logic [7:0] MIN_LENGTH      = 8'd2;
    localparam logic [7:0] LEN_INTERFACE   = 8'd9;
    localparam logic [7:0] LEN_CS          = 8'd3;
    localparam logic [7:0] LEN_HEADER      = 8'd8;
    localparam logic [7:0] LEN_FORMAT      = 8'd11;
    localparam logic [7:0] LEN_ENDPOINT    = 8'd7;
    localparam logic [7:0] LEN_EP_LONG     = 8'd9;
    localparam logic [7:0] FIRST_RATE_OFF  = 8'd8;

    // Endpoint attribute field codes.
    localparam logic [1:0] EP_ISOCHRONOUS = 2'b01;
    localparam logic [1:0] SYNC_ASYNC     = 2'b01;
    localparam logic [1:0] USAGE_FEEDBACK = 2'b01;
    localparam logic [1:0] USAGE_IMPLICIT = 2'b10;

    typedef struct packed {
        logic walk;
        logic load_desc;
        logic rate_read;
        logic load_rate;
        logic load_verdict;
        logic last;
    } uadw_cmd_t;

    typedef struct packed {
        logic desc_end;
        logic desc_rec;
        logic desc_rates;
        logic rate_last;
    } uadw_status_t;

endpackage

// ===== src/uadw_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module uadw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/uadw_ctrl.sv =====
// Controller of the USB audio descriptor walker: sequences byte intake, record emission
// and the output valid flag. Depends on uadw_pkg.
module uadw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  final_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output uadw_pkg::uadw_cmd_t   cmd,
    input  uadw_pkg::uadw_status_t status
);

    uadw_pkg::uadw_state_t state_reg, state_next;
    logic fin_reg, fin_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic load_any;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uadw_pkg::ST_IDLE;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            uadw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.walk = 1'b1;
                    fin_next = final_byte;
                    if (status.desc_end)
                    begin
                        state_next = uadw_pkg::ST_DESC;
                    end
                    else if (final_byte)
                    begin
                        state_next = uadw_pkg::ST_VERDICT;
                    end
                end
            end
            uadw_pkg::ST_DESC:
            begin
                if (!status.desc_rec)
                begin
                    state_next = fin_reg ? uadw_pkg::ST_VERDICT : uadw_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.load_desc = 1'b1;
                    cmd.last      = !fin_reg && !status.desc_rates;
                    if (status.desc_rates)
                    begin
                        state_next = uadw_pkg::ST_RATE_RD;
                    end
                    else
                    begin
                        state_next = fin_reg ? uadw_pkg::ST_VERDICT : uadw_pkg::ST_IDLE;
                    end
                end
            end
            uadw_pkg::ST_RATE_RD:
            begin
                cmd.rate_read = 1'b1;
                state_next    = uadw_pkg::ST_RATE;
            end
            uadw_pkg::ST_RATE:
            begin
                if (out_free)
                begin
                    cmd.load_rate = 1'b1;
                    cmd.last      = !fin_reg && status.rate_last;
                    if (status.rate_last)
                    begin
                        state_next = fin_reg ? uadw_pkg::ST_VERDICT : uadw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = uadw_pkg::ST_RATE_RD;
                    end
                end
            end
            uadw_pkg::ST_VERDICT:
            begin
                if (out_free)
                begin
                    cmd.load_verdict = 1'b1;
                    cmd.last         = 1'b1;
                    fin_next         = 1'b0;
                    state_next       = uadw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uadw_pkg::ST_IDLE;
            end
        endcase
    end

    assign load_any = cmd.load_desc || cmd.load_rate || cmd.load_verdict;

    always_comb
    begin
        if (load_any)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // A new record is only written into a free output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_any |-> (!out_valid_reg || out_ready))
        else $error("record loaded over an untaken record");

    // The verdict ends the set and returns to intake with no final mark pending.
    a_verdict_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_verdict |=> (state_reg == uadw_pkg::ST_IDLE && !fin_reg))
        else $error("verdict did not close the descriptor set");

    // No byte is taken while a final mark still awaits its verdict.
    a_no_intake_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !fin_reg)
        else $error("byte taken while a verdict is pending");

    // Every rate record is preceded by a memory read.
    a_rate_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uadw_pkg::ST_RATE && $past(state_reg) != uadw_pkg::ST_RATE)
        |-> $past(state_reg) == uadw_pkg::ST_RATE_RD)
        else $error("rate record without a preceding read");

endmodule

// ===== src/uadw_datapath.sv =====
// Datapath of the USB audio descriptor walker: walk counters, header bytes, rate
// assembly and store, descriptor decode, flags and the output record register.
// Depends on uadw_pkg and uadw_ram.
module uadw_datapath #(
    parameter int MAX_BYTES = 1024,
    parameter int MAX_RATES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  uadw_pkg::uadw_cmd_t    cmd,
    output uadw_pkg::uadw_status_t status,
    output logic [2:0]             record_kind,
    output logic [7:0]             number_a,
    output logic [7:0]             number_b,
    output logic [7:0]             number_c,
    output logic [7:0]             number_d,
    output logic [7:0]             number_e,
    output logic [23:0]            wide_value,
    output logic                   long_endpoint,
    output logic [2:0]             verdict_code,
    output logic                   rates_dropped,
    output logic                   last_of_run
);

    localparam int BTW = $clog2(MAX_BYTES + 1);
    localparam int AW  = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
    localparam int RW  = $clog2(MAX_RATES + 1);

    logic [BTW-1:0] byte_total_reg, byte_total_next;
    logic [7:0]     offset_reg, offset_next;
    logic [7:0]     length_reg, length_next;
    logic [7:0]     type_reg, type_next;
    logic [1:0]     pos_reg, pos_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic [7:0]     class_reg, class_next;
    logic [7:0]     subclass_reg, subclass_next;
    logic [3:0]     flags_reg, flags_next;
    logic           stopped_reg, stopped_next;
    logic [RW-1:0]  rate_idx_reg, rate_idx_next;

    logic [7:0]     hdr_reg [7];
    logic [15:0]    stage_reg;

    logic           under_limit;
    logic           active;
    logic [8:0]     off_inc;
    logic           hdr_wr;
    logic           stage_lo_wr;
    logic           stage_hi_wr;
    logic           ram_wr;
    logic [23:0]    ram_rd_data;

    logic [7:0]     hb2, hb3, hb4, hb5, hb6, hb7, hb8;
    logic           is_if, is_cs, is_hdr, is_fmt, is_ep, ep_long;
    logic [7:0]     refresh, synch;
    logic [7:0]     avail;
    logic           dropped;
    logic [RW-1:0]  shown;
    logic [2:0]     vc;

    assign hb2 = hdr_reg[0];
    assign hb3 = hdr_reg[1];
    assign hb4 = hdr_reg[2];
    assign hb5 = hdr_reg[3];
    assign hb6 = hdr_reg[4];
    assign hb7 = hdr_reg[5];
    assign hb8 = hdr_reg[6];

    assign under_limit = byte_total_reg < BTW'(MAX_BYTES);
    assign active      = cmd.walk && under_limit && !stopped_reg;
    assign off_inc     = {1'b0, offset_reg} + 9'd1;

    // Descriptor decode from the stored header bytes.
    always_comb
    begin
        is_if   = type_reg == uadw_pkg::DT_INTERFACE && length_reg >= uadw_pkg::LEN_INTERFACE;
        is_cs   = type_reg == uadw_pkg::DT_CS_INTERFACE && length_reg >= uadw_pkg::LEN_CS
                  && class_reg == uadw_pkg::CLASS_AUDIO;
        is_hdr  = is_cs && subclass_reg == uadw_pkg::SUBCLASS_CTRL
                  && hb2 == uadw_pkg::SUBTYPE_HEADER && length_reg >= uadw_pkg::LEN_HEADER;
        is_fmt  = is_cs && subclass_reg == uadw_pkg::SUBCLASS_STREAM
                  && hb2 == uadw_pkg::SUBTYPE_FORMAT && length_reg >= uadw_pkg::LEN_FORMAT;
        is_ep   = type_reg == uadw_pkg::DT_ENDPOINT && length_reg >= uadw_pkg::LEN_ENDPOINT;
        ep_long = length_reg >= uadw_pkg::LEN_EP_LONG;
        refresh = ep_long ? hb7 : 8'd0;
        synch   = ep_long ? hb8 : 8'd0;
        // Rates present are bounded by the advertised count and by complete triplets.
        avail   = (hb7 < {1'b0, cnt_reg}) ? hb7 : {1'b0, cnt_reg};
        dropped = avail > 8'(MAX_RATES);
        shown   = dropped ? RW'(MAX_RATES) : RW'(avail);
    end

    always_comb
    begin
        if (!flags_reg[uadw_pkg::FLAG_AUDIO])
        begin
            vc = uadw_pkg::VC_NOT_AUDIO;
        end
        else if (flags_reg[uadw_pkg::FLAG_ASYNC] && flags_reg[uadw_pkg::FLAG_EXPL])
        begin
            vc = uadw_pkg::VC_ASYNC_EXPLICIT;
        end
        else if (flags_reg[uadw_pkg::FLAG_ASYNC] && flags_reg[uadw_pkg::FLAG_IMPL])
        begin
            vc = uadw_pkg::VC_ASYNC_IMPLICIT;
        end
        else if (flags_reg[uadw_pkg::FLAG_ASYNC])
        begin
            vc = uadw_pkg::VC_ASYNC_NONE;
        end
        else
        begin
            vc = uadw_pkg::VC_ADAPTIVE_SYNC;
        end
    end

    assign status.desc_end   = active && offset_reg != 8'd0
                               && off_inc >= {1'b0, length_reg};
    assign status.desc_rec   = is_if || is_hdr || is_fmt || is_ep;
    assign status.desc_rates = is_fmt && shown != '0;
    assign status.rate_last  = rate_idx_reg == shown - RW'(1);

    // Walk, interface tracking and flag updates.
    always_comb
    begin
        byte_total_next = byte_total_reg;
        offset_next     = offset_reg;
        length_next     = length_reg;
        type_next       = type_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        class_next      = class_reg;
        subclass_next   = subclass_reg;
        flags_next      = flags_reg;
        stopped_next    = stopped_reg;
        rate_idx_next   = rate_idx_reg;
        hdr_wr          = 1'b0;
        stage_lo_wr     = 1'b0;
        stage_hi_wr     = 1'b0;
        ram_wr          = 1'b0;

        if (cmd.walk && under_limit)
        begin
            byte_total_next = byte_total_reg + 1'b1;
        end

        if (active)
        begin
            if (offset_reg == 8'd0)
            begin
                if (data_byte < uadw_pkg::MIN_LENGTH)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    length_next = data_byte;
                    pos_next    = 2'd0;
                    cnt_next    = 7'd0;
                    offset_next = 8'd1;
                end
            end
            else
            begin
                if (offset_reg == 8'd1)
                begin
                    type_next = data_byte;
                end
                if (offset_reg >= 8'd2 && offset_reg <= uadw_pkg::FIRST_RATE_OFF)
                begin
                    hdr_wr = 1'b1;
                end
                if (offset_reg >= uadw_pkg::FIRST_RATE_OFF)
                begin
                    case (pos_reg)
                        2'd0:    stage_lo_wr = 1'b1;
                        2'd1:    stage_hi_wr = 1'b1;
                        default:
                        begin
                            ram_wr   = cnt_reg < 7'(MAX_RATES);
                            cnt_next = cnt_reg + 7'd1;
                        end
                    endcase
                    pos_next = (pos_reg == 2'd2) ? 2'd0 : pos_reg + 2'd1;
                end
                offset_next = (off_inc >= {1'b0, length_reg}) ? 8'd0 : off_inc[7:0];
            end
        end

        if (cmd.load_desc)
        begin
            rate_idx_next = '0;
            if (is_if)
            begin
                class_next    = hb5;
                subclass_next = hb6;
                if (hb5 == uadw_pkg::CLASS_AUDIO)
                begin
                    flags_next[uadw_pkg::FLAG_AUDIO] = 1'b1;
                end
            end
            else if (is_ep && class_reg == uadw_pkg::CLASS_AUDIO
                     && hb3[1:0] == uadw_pkg::EP_ISOCHRONOUS)
            begin
                if (hb3[3:2] == uadw_pkg::SYNC_ASYNC)
                begin
                    flags_next[uadw_pkg::FLAG_ASYNC] = 1'b1;
                end
                if (hb3[5:4] == uadw_pkg::USAGE_FEEDBACK || (ep_long && synch != 8'd0))
                begin
                    flags_next[uadw_pkg::FLAG_EXPL] = 1'b1;
                end
                if (hb3[5:4] == uadw_pkg::USAGE_IMPLICIT)
                begin
                    flags_next[uadw_pkg::FLAG_IMPL] = 1'b1;
                end
            end
        end

        if (cmd.load_rate)
        begin
            rate_idx_next = rate_idx_reg + RW'(1);
        end

        if (cmd.load_verdict)
        begin
            byte_total_next = '0;
            offset_next     = 8'd0;
            length_next     = 8'd0;
            type_next       = 8'd0;
            pos_next        = 2'd0;
            cnt_next        = 7'd0;
            class_next      = 8'd0;
            subclass_next   = 8'd0;
            flags_next      = 4'd0;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg <= '0;
            offset_reg     <= 8'd0;
            length_reg     <= 8'd0;
            type_reg       <= 8'd0;
            pos_reg        <= 2'd0;
            cnt_reg        <= 7'd0;
            class_reg      <= 8'd0;
            subclass_reg   <= 8'd0;
            flags_reg      <= 4'd0;
            stopped_reg    <= 1'b0;
            rate_idx_reg   <= '0;
        end
        else
        begin
            byte_total_reg <= byte_total_next;
            offset_reg     <= offset_next;
            length_reg     <= length_next;
            type_reg       <= type_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            class_reg      <= class_next;
            subclass_reg   <= subclass_next;
            flags_reg      <= flags_next;
            stopped_reg    <= stopped_next;
            rate_idx_reg   <= rate_idx_next;
        end
    end

    // Header bytes and the partial rate carry no reset.
    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            hdr_reg[3'(offset_reg - 8'd2)] <= data_byte;
        end
        if (stage_lo_wr)
        begin
            stage_reg[7:0] <= data_byte;
        end
        if (stage_hi_wr)
        begin
            stage_reg[15:8] <= data_byte;
        end
    end

    uadw_ram #(
        .WIDTH (24),
        .DEPTH (MAX_RATES)
    ) u_rate_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({data_byte, stage_reg}),
        .rd_en   (cmd.rate_read),
        .rd_addr (rate_idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Output record register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_desc || cmd.load_rate || cmd.load_verdict)
        begin
            record_kind   <= uadw_pkg::KIND_RATE;
            number_a      <= 8'd0;
            number_b      <= 8'd0;
            number_c      <= 8'd0;
            number_d      <= 8'd0;
            number_e      <= 8'd0;
            wide_value    <= 24'd0;
            long_endpoint <= 1'b0;
            verdict_code  <= 3'd0;
            rates_dropped <= 1'b0;
            last_of_run   <= cmd.last;
            if (cmd.load_verdict)
            begin
                record_kind  <= uadw_pkg::KIND_VERDICT;
                wide_value   <= {{(24 - BTW){1'b0}}, byte_total_reg};
                verdict_code <= vc;
            end
            else if (cmd.load_rate)
            begin
                wide_value <= ram_rd_data;
            end
            else if (is_if)
            begin
                record_kind <= uadw_pkg::KIND_INTERFACE;
                number_a    <= hb2;
                number_b    <= hb3;
                number_c    <= hb5;
                number_d    <= hb6;
                number_e    <= hb4;
            end
            else if (is_hdr)
            begin
                record_kind <= uadw_pkg::KIND_VERSION;
                number_a    <= hb4;
                number_b    <= hb3;
            end
            else if (is_fmt)
            begin
                record_kind   <= uadw_pkg::KIND_FORMAT;
                number_a      <= hb4;
                number_b      <= hb6;
                number_c      <= hb7;
                rates_dropped <= dropped;
            end
            else
            begin
                record_kind   <= uadw_pkg::KIND_ENDPOINT;
                number_a      <= hb2;
                number_b      <= hb3;
                number_c      <= refresh;
                number_d      <= synch;
                wide_value    <= {8'd0, hb5, hb4};
                long_endpoint <= ep_long;
            end
        end
    end

endmodule

// ===== src/usb_audio_descriptor_walker_unit.sv =====
// Top level of the USB audio descriptor walker.
// Depends on uadw_pkg, uadw_ctrl and uadw_datapath (which holds uadw_ram).
//
// Usage. The input channel (in_valid, in_ready, data_byte, final_byte) carries one byte of
// a USB configuration descriptor set per request; final_byte marks the last byte of the
// set. The output channel (out_valid, out_ready and the record fields) carries records:
// interface, audio header version, format, sample rate, endpoint and the closing verdict.
// last_of_run is set on the final record caused by one input byte.
// Timing. A byte that completes no descriptor leaves the walker ready for the next byte. A
// byte that completes a descriptor adds a decode state, in which a recognised descriptor's
// record is loaded into the output register once that register is free. Each sample-rate
// record then passes through a registered read of the rate memory before it is loaded. A
// final byte adds a state for the verdict.
// Stalls. Records wait in a single output register; the next byte is taken while a
// record waits, but a further record is only loaded once the receiver has taken the one
// before, so in_ready stays low while a further record waits to be loaded.
// Reset. rst_n clears the walk, the interface tracking, the flags and the byte count; the
// verdict does the same at the end of each set. Header bytes and the rate memory are
// not cleared, since nothing is read from them before it has been written.
module usb_audio_descriptor_walker_unit #(
    parameter int MAX_BYTES = 1024,
    parameter int MAX_RATES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  record_kind,
    output logic [7:0]  number_a,
    output logic [7:0]  number_b,
    output logic [7:0]  number_c,
    output logic [7:0]  number_d,
    output logic [7:0]  number_e,
    output logic [23:0] wide_value,
    output logic        long_endpoint,
    output logic [2:0]  verdict_code,
    output logic        rates_dropped,
    output logic        last_of_run
);

    uadw_pkg::uadw_cmd_t    cmd;
    uadw_pkg::uadw_status_t status;

    // The controller sequences intake and emission; all data lives in the datapath.
    uadw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status)
    );

    uadw_datapath #(
        .MAX_BYTES (MAX_BYTES),
        .MAX_RATES (MAX_RATES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .status        (status),
        .record_kind   (record_kind),
        .number_a      (number_a),
        .number_b      (number_b),
        .number_c      (number_c),
        .number_d      (number_d),
        .number_e      (number_e),
        .wide_value    (wide_value),
        .long_endpoint (long_endpoint),
        .verdict_code  (verdict_code),
        .rates_dropped (rates_dropped),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for usb_audio_descriptor_walker_unit: drives descriptor sets byte
// by byte, predicts every record with its own walker model and checks the records in order.
// Depends on uadw_pkg and the walker unit.
module tb_top;

    import uadw_pkg::*;

    localparam int WALK_MAX_BYTES = 1024;
    localparam int WALK_MAX_RATES = 8;
    localparam int RATE_BASE      = FIRST_RATE_OFF;
    localparam int RANDOM_BYTES   = 270;
    // Settling time once the last record is in: decode, rate read and verdict cycles.
    localparam int SETTLE_CYCLES  = 20;

    // One record as the output channel presents it.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  num_a;
        logic [7:0]  num_b;
        logic [7:0]  num_c;
        logic [7:0]  num_d;
        logic [7:0]  num_e;
        logic [23:0] wide;
        logic        long_ep;
        logic [2:0]  code;
        logic        dropped;
        logic        run_end;
    } walker_record_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  record_kind;
    logic [7:0]  number_a;
    logic [7:0]  number_b;
    logic [7:0]  number_c;
    logic [7:0]  number_d;
    logic [7:0]  number_e;
    logic [23:0] wide_value;
    logic        long_endpoint;
    logic [2:0]  verdict_code;
    logic        rates_dropped;
    logic        last_of_run;

    // Records the walker owes us, oldest first, and the mismatches found so far.
    walker_record_t expected_records[$];
    walker_record_t head_rec;
    int             mismatch_count = 0;

    // Shadow copy of the walker's state, kept in step with every accepted request.
    int          walked_bytes;
    int          desc_offset;
    logic [7:0]  desc_len;
    logic [7:0]  desc_kind;
    logic [7:0]  head_bytes[0:6];
    logic [23:0] rate_words[0:WALK_MAX_RATES-1];
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [3:0]  seen;
    logic        walk_halted;

    // Records caused by the byte currently being predicted.
    walker_record_t byte_records[0:15];
    int             byte_record_count;

    // Descriptor set under construction, and the fields of the descriptor being built.
    logic [7:0] set_bytes[$];
    logic [7:0] desc_fields[0:63];

    // Idling controls for the two channels.
    bit feed_gaps = 1'b1;
    bit drain_stalls = 1'b1;
    int drain_hold = 0;

    usb_audio_descriptor_walker_unit #(
        .MAX_BYTES(WALK_MAX_BYTES),
        .MAX_RATES(WALK_MAX_RATES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .final_byte(final_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .record_kind(record_kind),
        .number_a(number_a),
        .number_b(number_b),
        .number_c(number_c),
        .number_d(number_d),
        .number_e(number_e),
        .wide_value(wide_value),
        .long_endpoint(long_endpoint),
        .verdict_code(verdict_code),
        .rates_dropped(rates_dropped),
        .last_of_run(last_of_run)
    );

    always #4 clk = ~clk;

    // Idle lengths for both channels: mostly none, sometimes a short pause and now and
    // then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    //--------------------------------------------------------------------------------------
    // Walker model
    //--------------------------------------------------------------------------------------

    function automatic void clear_walker_state();
        walked_bytes = 0;
        desc_offset = 0;
        desc_len = 8'h00;
        desc_kind = 8'h00;
        iface_class = 8'h00;
        iface_subclass = 8'h00;
        seen = 4'b0000;
        walk_halted = 1'b0;
    endfunction

    function automatic void emit_record(input logic [2:0] kind, input logic [7:0] a,
                                        input logic [7:0] b, input logic [7:0] c,
                                        input logic [7:0] d, input logic [7:0] e,
                                        input logic [23:0] wide, input logic lng,
                                        input logic [2:0] code, input logic drop);
        walker_record_t rec;
        rec.kind = kind;
        rec.num_a = a;
        rec.num_b = b;
        rec.num_c = c;
        rec.num_d = d;
        rec.num_e = e;
        rec.wide = wide;
        rec.long_ep = lng;
        rec.code = code;
        rec.dropped = drop;
        rec.run_end = 1'b0;
        byte_records[byte_record_count] = rec;
        byte_record_count++;
    endfunction

    // Advances the shadow state by one accepted byte and queues the records it causes.
    // head_bytes[i] holds byte i + 2 of the current descriptor.
    task automatic predict_walker_byte(input logic [7:0] value, input logic is_last);
        int off;
        int rate_pos;
        int slot;
        int len_now;
        int nfreq;
        int avail;
        int shown;
        logic [7:0] attr;
        logic [7:0] refresh;
        logic [7:0] synch;
        logic       is_long;
        logic [2:0] code;
        byte_record_count = 0;
        // Bytes beyond the byte limit are neither counted nor walked.
        if (walked_bytes < WALK_MAX_BYTES)
        begin
            walked_bytes++;
            if (!walk_halted)
            begin
                off = desc_offset;
                if (off == 0 && value < MIN_LENGTH)
                begin
                    // A length below two ends the walk until the final byte.
                    walk_halted = 1'b1;
                end
                else
                begin
                    if (off == 0)
                        desc_len = value;
                    else if (off == 1)
                        desc_kind = value;
                    if (off >= 2 && off <= 8)
                        head_bytes[off - 2] = value;
                    // Rates are assembled little-endian, three bytes each.
                    if (off >= RATE_BASE)
                    begin
                        rate_pos = off - RATE_BASE;
                        slot = rate_pos / 3;
                        if (slot < WALK_MAX_RATES)
                        begin
                            if (rate_pos % 3 == 0)
                                rate_words[slot] = {16'h0000, value};
                            else
                                rate_words[slot] = rate_words[slot]
                                    | ({16'h0000, value} << (8 * (rate_pos % 3)));
                        end
                    end
                    off++;
                    len_now = desc_len;
                    if (off < len_now)
                    begin
                        desc_offset = off;
                    end
                    else
                    begin
                        desc_offset = 0;
                        if (desc_kind == DT_INTERFACE && len_now >= LEN_INTERFACE)
                        begin
                            iface_class = head_bytes[3];
                            iface_subclass = head_bytes[4];
                            if (iface_class == CLASS_AUDIO)
                                seen[FLAG_AUDIO] = 1'b1;
                            emit_record(KIND_INTERFACE, head_bytes[0], head_bytes[1],
                                        iface_class, iface_subclass, head_bytes[2],
                                        24'h0, 1'b0, 3'd0, 1'b0);
                        end
                        else if (desc_kind == DT_CS_INTERFACE && len_now >= LEN_CS
                                 && iface_class == CLASS_AUDIO)
                        begin
                            if (iface_subclass == SUBCLASS_CTRL
                                && head_bytes[0] == SUBTYPE_HEADER && len_now >= LEN_HEADER)
                            begin
                                emit_record(KIND_VERSION, head_bytes[2], head_bytes[1],
                                            8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 3'd0, 1'b0);
                            end
                            else if (iface_subclass == SUBCLASS_STREAM
                                     && head_bytes[0] == SUBTYPE_FORMAT
                                     && len_now >= LEN_FORMAT)
                            begin
                                // A rate counts only if all three of its bytes are inside
                                // the descriptor; the surplus beyond the store is flagged.
                                nfreq = head_bytes[5];
                                avail = 0;
                                while (avail < nfreq && 3 * avail + 10 < len_now)
                                    avail++;
                                shown = (avail < WALK_MAX_RATES) ? avail : WALK_MAX_RATES;
                                emit_record(KIND_FORMAT, head_bytes[2], head_bytes[4],
                                            head_bytes[5], 8'h00, 8'h00, 24'h0, 1'b0, 3'd0,
                                            avail > WALK_MAX_RATES);
                                for (int k = 0; k < shown; k++)
                                    emit_record(KIND_RATE, 8'h00, 8'h00, 8'h00, 8'h00,
                                                8'h00, rate_words[k], 1'b0, 3'd0, 1'b0);
                            end
                        end
                        else if (desc_kind == DT_ENDPOINT && len_now >= LEN_ENDPOINT)
                        begin
                            attr = head_bytes[1];
                            is_long = (len_now >= LEN_EP_LONG);
                            refresh = is_long ? head_bytes[5] : 8'h00;
                            synch = is_long ? head_bytes[6] : 8'h00;
                            emit_record(KIND_ENDPOINT, head_bytes[0], attr, refresh, synch,
                                        8'h00, {8'h00, head_bytes[3], head_bytes[2]},
                                        is_long, 3'd0, 1'b0);
                            // Only isochronous endpoints of an audio interface count.
                            if (iface_class == CLASS_AUDIO && attr[1:0] == EP_ISOCHRONOUS)
                            begin
                                if (attr[3:2] == SYNC_ASYNC)
                                    seen[FLAG_ASYNC] = 1'b1;
                                if (attr[5:4] == USAGE_FEEDBACK)
                                    seen[FLAG_EXPL] = 1'b1;
                                if (is_long && synch != 8'h00)
                                    seen[FLAG_EXPL] = 1'b1;
                                if (attr[5:4] == USAGE_IMPLICIT)
                                    seen[FLAG_IMPL] = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        if (is_last)
        begin
            if (!seen[FLAG_AUDIO])
                code = VC_NOT_AUDIO;
            else if (seen[FLAG_ASYNC] && seen[FLAG_EXPL])
                code = VC_ASYNC_EXPLICIT;
            else if (seen[FLAG_ASYNC] && seen[FLAG_IMPL])
                code = VC_ASYNC_IMPLICIT;
            else if (seen[FLAG_ASYNC])
                code = VC_ASYNC_NONE;
            else
                code = VC_ADAPTIVE_SYNC;
            emit_record(KIND_VERDICT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, walked_bytes[23:0],
                        1'b0, code, 1'b0);
            clear_walker_state();
        end
        if (byte_record_count > 0)
            byte_records[byte_record_count - 1].run_end = 1'b1;
        for (int i = 0; i < byte_record_count; i++)
            expected_records.push_back(byte_records[i]);
    endtask

    //--------------------------------------------------------------------------------------
    // Input channel
    //--------------------------------------------------------------------------------------

    // Offers one byte as a request, after an optional gap, and predicts its records once
    // the walker has taken it. Valid is only lowered when a gap follows, so it is never
    // dropped and raised in the same step.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = feed_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= value;
        final_byte <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_walker_byte(value, is_last);
    endtask

    // Sends the first count bytes of the set under construction, marking the last one
    // sent as final; zero or too large a count sends the whole set.
    task automatic send_set(input int count);
        if (count <= 0 || count > set_bytes.size())
            count = set_bytes.size();
        for (int i = 0; i < count; i++)
            send_byte(set_bytes[i], i == count - 1);
        set_bytes.delete();
    endtask

    //--------------------------------------------------------------------------------------
    // Descriptor builders
    //--------------------------------------------------------------------------------------

    // Fills a fresh descriptor with random content; builders then overwrite the fields that
    // steer the walk.
    function automatic void start_desc();
        for (int i = 0; i < 64; i++)
            desc_fields[i] = $urandom_range(0, 255);
    endfunction

    function automatic void commit_desc(input int len);
        logic [7:0] v;
        desc_fields[0] = len;
        for (int i = 0; i < len; i++)
        begin
            v = (i < 64) ? desc_fields[i] : $urandom_range(0, 255);
            set_bytes.push_back(v);
        end
    endfunction

    function automatic void put_interface(input logic [7:0] cls, input logic [7:0] sub,
                                          input int len);
        start_desc();
        desc_fields[1] = DT_INTERFACE;
        desc_fields[5] = cls;
        desc_fields[6] = sub;
        commit_desc(len);
    endfunction

    function automatic void put_header(input int len);
        start_desc();
        desc_fields[1] = DT_CS_INTERFACE;
        desc_fields[2] = SUBTYPE_HEADER;
        commit_desc(len);
    endfunction

    // A format descriptor with nfreq announced rates, room for present of them and extra
    // trailing bytes.
    function automatic void put_format(input int nfreq, input int present, input int extra);
        int len;
        start_desc();
        desc_fields[1] = DT_CS_INTERFACE;
        desc_fields[2] = SUBTYPE_FORMAT;
        desc_fields[7] = nfreq;
        len = RATE_BASE + 3 * present + extra;
        if (len < LEN_FORMAT)
            len = LEN_FORMAT;
        commit_desc(len);
    endfunction

    function automatic void put_endpoint(input logic [7:0] attr, input int len,
                                         input logic [7:0] synch);
        start_desc();
        desc_fields[1] = DT_ENDPOINT;
        desc_fields[3] = attr;
        desc_fields[8] = synch;
        commit_desc(len);
    endfunction

    function automatic void put_other(input logic [7:0] kind, input int len);
        start_desc();
        desc_fields[1] = kind;
        commit_desc(len);
    endfunction

    // One well-formed descriptor of a random sort with random content.
    function automatic void put_random_descriptor();
        int r;
        int q;
        int nfreq;
        int present;
        int len;
        logic [7:0] cls;
        logic [7:0] sub;
        logic [7:0] attr;
        r = $urandom_range(0, 99);
        if (r < 22)
        begin
            cls = ($urandom_range(0, 3) != 0) ? CLASS_AUDIO : $urandom_range(0, 255);
            q = $urandom_range(0, 2);
            sub = (q == 0) ? SUBCLASS_CTRL : (q == 1) ? SUBCLASS_STREAM : $urandom_range(0, 255);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : LEN_INTERFACE;
            put_interface(cls, sub, len);
        end
        else if (r < 37)
        begin
            put_header(($urandom_range(0, 7) == 0) ? $urandom_range(3, 7) : $urandom_range(8, 12));
        end
        else if (r < 60)
        begin
            q = $urandom_range(0, 9);
            if (q == 0)
            begin
                nfreq = 0;
                present = $urandom_range(0, 2);
            end
            else if (q == 1)
            begin
                // More rates announced than the store keeps.
                nfreq = $urandom_range(9, 255);
                present = $urandom_range(7, 12);
            end
            else if (q == 2)
            begin
                // Room for one rate fewer than announced, before any trailing bytes.
                nfreq = $urandom_range(2, 6);
                present = nfreq - 1;
            end
            else
            begin
                nfreq = $urandom_range(1, 4);
                present = nfreq;
            end
            put_format(nfreq, present,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        end
        else if (r < 88)
        begin
            attr = $urandom_range(0, 255);
            if ($urandom_range(0, 3) != 0)
                attr[1:0] = EP_ISOCHRONOUS;
            q = $urandom_range(0, 5);
            len = (q == 0) ? 7 : (q == 1) ? 8 : (q == 4) ? 10 :
                  (q == 5) ? $urandom_range(2, 6) : 9;
            put_endpoint(attr, len, $urandom_range(0, 1) ? 8'h00 : $urandom_range(0, 255));
        end
        else
        begin
            put_other($urandom_range(0, 255), $urandom_range(2, 16));
        end
    endfunction

    //--------------------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------------------

    // Every record kind in one audio set: control interface, header version, streaming
    // interface, a format with the widest and narrowest rates, and a long endpoint whose
    // synch address signals explicit feedback.
    task automatic test_record_kinds();
        put_interface(CLASS_AUDIO, SUBCLASS_CTRL, LEN_INTERFACE);
        put_header(9);
        put_interface(CLASS_AUDIO, SUBCLASS_STREAM, LEN_INTERFACE);
        start_desc();
        desc_fields[1] = DT_CS_INTERFACE;
        desc_fields[2] = SUBTYPE_FORMAT;
        desc_fields[4] = 8'hFF;
        desc_fields[6] = 8'h00;
        desc_fields[7] = 8'd2;
        for (int i = 8; i < 11; i++)
            desc_fields[i] = 8'hFF;
        for (int i = 11; i < 14; i++)
            desc_fields[i] = 8'h00;
        commit_desc(14);
        put_endpoint(8'h05, 9, 8'h81);
        send_set(0);
    endtask

    // Rate lists: more rates than kept, none announced, a list cut short by the length,
    // trailing bytes after the list; closed by a short endpoint with implicit feedback.
    task automatic test_rate_list();
        put_interface(CLASS_AUDIO, SUBCLASS_STREAM, LEN_INTERFACE);
        put_format(255, 10, 0);
        put_format(0, 0, 0);
        put_format(5, 2, 0);
        put_format(1, 1, 3);
        put_endpoint(8'h25, 7, 8'h00);
        send_set(0);
    endtask

    // Short lengths, cut-off descriptors and the longest possible descriptor.
    task automatic test_walk_stops();
        // An adaptive endpoint, then a length of one halts the walk; the rest is ignored.
        put_interface(CLASS_AUDIO, SUBCLASS_STREAM, LEN_INTERFACE);
        put_endpoint(8'h09, 7, 8'h00);
        set_bytes.push_back(8'h01);
        put_interface(CLASS_AUDIO, SUBCLASS_CTRL, LEN_INTERFACE);
        send_set(0);
        // A zero length as the only byte of a set.
        set_bytes.push_back(8'h00);
        send_set(0);
        // Asynchronous without feedback, then a header cut off by the final byte.
        put_interface(CLASS_AUDIO, SUBCLASS_CTRL, LEN_INTERFACE);
        put_endpoint(8'h05, 7, 8'h00);
        put_header(LEN_HEADER);
        send_set(set_bytes.size() - 3);
        // A lone final byte that opens a descriptor of the largest length.
        set_bytes.push_back(8'hFF);
        send_set(0);
        // An interface descriptor of the largest length is still recognised.
        put_interface(CLASS_AUDIO, SUBCLASS_CTRL, 255);
        send_set(0);
    endtask

    // Random sets, mostly well formed, with cut-off sets, halted walks and plain noise
    // mixed in. Each set picks its own idling so that some stretches run flat out.
    task automatic test_random_sets();
        int sent;
        int r;
        int count;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 3);
            feed_gaps = (r == 0 || r == 2);
            drain_stalls = (r == 0 || r == 3);
            if ($urandom_range(0, 9) != 0)
                put_interface(CLASS_AUDIO,
                              $urandom_range(0, 1) ? SUBCLASS_STREAM : SUBCLASS_CTRL,
                              LEN_INTERFACE);
            r = $urandom_range(0, 99);
            if (r < 93)
            begin
                repeat ($urandom_range(1, 5)) put_random_descriptor();
            end
            else
            begin
                set_bytes.delete();
                repeat ($urandom_range(1, 12)) set_bytes.push_back($urandom_range(0, 255));
            end
            if (r >= 85 && r < 93)
            begin
                // A short length after the last complete descriptor halts the walk.
                set_bytes.push_back($urandom_range(0, 1));
                repeat ($urandom_range(1, 6)) set_bytes.push_back($urandom_range(0, 255));
            end
            count = (r >= 75 && r < 85) ? $urandom_range(1, set_bytes.size()) : set_bytes.size();
            sent += count;
            send_set(count);
        end
        feed_gaps = 1'b1;
        drain_stalls = 1'b1;
    endtask

    // One set longer than the byte limit: the descriptor crossing the limit is never
    // finished and the verdict reports the limit as the byte count.
    task automatic test_byte_limit();
        while (set_bytes.size() < WALK_MAX_BYTES + 16)
            put_random_descriptor();
        send_set(0);
    endtask

    //--------------------------------------------------------------------------------------
    // Output channel
    //--------------------------------------------------------------------------------------

    // The receiver stalls now and then; a stall holds out_ready low for its whole length.
    always @(negedge clk)
    begin
        if (drain_hold > 0)
        begin
            drain_hold--;
        end
        else if (drain_stalls && (drain_hold = pick_gap()) > 0)
        begin
            out_ready <= 1'b0;
            drain_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every record taken by the receiver must match the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_records.size() == 0)
            begin
                $error("record_kind: expected no record, got 0x%0h", record_kind);
                mismatch_count++;
            end
            else
            begin
                head_rec = expected_records.pop_front();
                check_field("record_kind", head_rec.kind, record_kind);
                check_field("number_a", head_rec.num_a, number_a);
                check_field("number_b", head_rec.num_b, number_b);
                check_field("number_c", head_rec.num_c, number_c);
                check_field("number_d", head_rec.num_d, number_d);
                check_field("number_e", head_rec.num_e, number_e);
                check_field("wide_value", head_rec.wide, wide_value);
                check_field("long_endpoint", head_rec.long_ep, long_endpoint);
                check_field("verdict_code", head_rec.code, verdict_code);
                check_field("rates_dropped", head_rec.dropped, rates_dropped);
                check_field("last_of_run", head_rec.run_end, last_of_run);
            end
        end
    end

    //--------------------------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------------------------

    initial
    begin
        clear_walker_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_record_kinds();
        test_rate_list();
        test_walk_stops();
        test_random_sets();
        test_byte_limit();
        @(negedge clk);
        in_valid <= 1'b0;
        // Wait for every outstanding record, then give the walker time to show anything
        // it should not.
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, sized well beyond the slowest legal run with all idling at its worst.
    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/uadw_pkg.sv
src/uadw_ram.sv
src/uadw_ctrl.sv
src/uadw_datapath.sv
src/usb_audio_descriptor_walker_unit.sv
verif/tb_top.sv
